>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro expects a clock named clock and, where noted, a reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, disabled while reset is high.
`define ASSERT_CLK_RST(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> sv/itp_pkg.sv
// ----------------------------------------------------------------------------
// Integer text parser package
// Request and response types shared by the parser core and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned VALUE_W = 64;

   // One character of a text, with its framing bits.
   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              has_char;
      logic              is_last;
      logic              signed_mode;
   } req_type;

   // One parse result, produced at the end of each text.
   typedef struct packed {
      logic               valid_res;
      logic [VALUE_W-1:0] value;
   } rsp_type;

endpackage

`default_nettype wire

>>> sv/itp_core.sv
// ----------------------------------------------------------------------------
// Integer text parser core
// Holds the per-text parse state and advances it by one character per step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module itp_core
   import itp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type item,
   output rsp_type      result
);

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_SIGN,
      PH_ZERO,
      PH_DEC,
      PH_HEX,
      PH_DONE
   } phase_type;

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CH_1     = 8'h31;
   localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
   localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
   localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
   localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

   phase_type          phase_ff, phase_in;
   logic               negative_ff, negative_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               seen_ff, seen_in;
   logic               mode_latched_ff;
   logic               signed_latched_ff;

   logic               signed_cur;
   logic [CHAR_W-1:0]  c;
   logic               is_blank, is_sign, is_dec, is_hex_alpha;
   logic [3:0]         hex_nibble;
   logic [VALUE_W-1:0] acc_dec, acc_hex;
   phase_type          start_phase;
   logic [VALUE_W-1:0] start_acc;
   logic               start_seen;

   assign c          = item.character;
   assign signed_cur = mode_latched_ff ? signed_latched_ff : item.signed_mode;

   // Character classes.
   assign is_blank     = (c == CH_SPACE) || (c == CH_TAB);
   assign is_sign      = (c == CH_PLUS) || (c == CH_MINUS);
   assign is_dec       = c inside {[CH_0:CH_9]};
   assign is_hex_alpha = c inside {[CH_LA:CH_LF], [CH_UA:CH_UF]};
   // Letters a-f and A-F both carry 1..6 in their low nibble.
   assign hex_nibble   = is_dec ? c[3:0] : c[3:0] + 4'd9;

   // Times ten as two shifts and an add, times sixteen as a plain shift.
   assign acc_dec = (acc_ff << 3) + (acc_ff << 1) + {{(VALUE_W-4){1'b0}}, c[3:0]};
   assign acc_hex = {acc_ff[VALUE_W-5:0], hex_nibble};

   // First character of the number itself, after blanks and sign.
   always_comb begin
      start_phase = PH_DONE;
      start_acc   = acc_ff;
      start_seen  = seen_ff;
      if (c == CH_0) begin
         start_phase = PH_ZERO;
         start_acc   = '0;
         start_seen  = 1'b1;
      end else if (c inside {[CH_1:CH_9]}) begin
         start_phase = PH_DEC;
         start_acc   = {{(VALUE_W-4){1'b0}}, c[3:0]};
         start_seen  = 1'b1;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      negative_in = negative_ff;
      acc_in      = acc_ff;
      seen_in     = seen_ff;
      if (item.has_char) begin
         case (phase_ff)
            PH_LEAD: begin
               if (!is_blank) begin
                  if (signed_cur && is_sign) begin
                     negative_in = (c == CH_MINUS);
                     phase_in    = PH_SIGN;
                  end else begin
                     phase_in = start_phase;
                     acc_in   = start_acc;
                     seen_in  = start_seen;
                  end
               end
            end
            PH_SIGN: begin
               if (!is_blank) begin
                  phase_in = start_phase;
                  acc_in   = start_acc;
                  seen_in  = start_seen;
               end
            end
            PH_ZERO: begin
               if ((c == CH_LX) || (c == CH_UX)) begin
                  phase_in = PH_HEX;
                  acc_in   = '0;
                  seen_in  = 1'b0;
               end else if (is_dec) begin
                  phase_in = PH_DEC;
                  acc_in   = acc_dec;
               end else begin
                  phase_in = PH_DONE;
               end
            end
            PH_DEC: begin
               if (is_dec) begin
                  acc_in = acc_dec;
               end else begin
                  phase_in = PH_DONE;
               end
            end
            PH_HEX: begin
               if (is_dec || is_hex_alpha) begin
                  acc_in  = acc_hex;
                  seen_in = 1'b1;
               end else begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
   end

   // The response is only used when the stepped item ends its text.
   assign result.valid_res = seen_in;
   assign result.value     = !seen_in    ? '0 :
                             negative_in ? ({VALUE_W{1'b0}} - acc_in) : acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_LEAD;
         negative_ff       <= 1'b0;
         acc_ff            <= '0;
         seen_ff           <= 1'b0;
         mode_latched_ff   <= 1'b0;
         signed_latched_ff <= 1'b0;
      end else if (step) begin
         if (item.is_last) begin
            phase_ff          <= PH_LEAD;
            negative_ff       <= 1'b0;
            acc_ff            <= '0;
            seen_ff           <= 1'b0;
            mode_latched_ff   <= 1'b0;
            signed_latched_ff <= 1'b0;
         end else begin
            phase_ff          <= phase_in;
            negative_ff       <= negative_in;
            acc_ff            <= acc_in;
            seen_ff           <= seen_in;
            mode_latched_ff   <= 1'b1;
            signed_latched_ff <= signed_cur;
         end
      end
   end

   `ASSERT_CLK_RST(a_end_clears, step && item.is_last |=> phase_ff == PH_LEAD && !mode_latched_ff && acc_ff == '0 && !seen_ff, "parse state not cleared after end of text")
   `ASSERT_CLK_RST(a_pre_number, (phase_ff == PH_LEAD || phase_ff == PH_SIGN) |-> acc_ff == '0 && !seen_ff, "digits recorded before the number started")
   `ASSERT_CLK_RST(a_hex_empty, phase_ff == PH_HEX && !seen_ff |-> acc_ff == '0, "hex value nonzero without a hex digit")

endmodule

`default_nettype wire

>>> sv/integer_text_parser.sv
// ----------------------------------------------------------------------------
// Integer text parser
// Parses decimal or 0x-prefixed hex integer text, one character per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid / req_stall / req_data, one character each,
//   with has_char, is_last and signed_mode beside it. A request with is_last
//   set closes the text and produces exactly one response on rsp_valid /
//   rsp_stall / rsp_data; all other requests produce none.
//   A last request is held in the input register, then loaded into the
//   response register, from which rsp_valid is driven.
//   Throughput: one request per cycle while req_stall is low. The parse
//   state takes one accumulator step per character, which sets the rate.
//   A stalled response blocks only the next last request; characters in the
//   middle of a text keep flowing, and req_stall rises only when a last
//   request sits in the input register while the response register is full
//   and stalled.
//   Reset clears the valid bits of both registers and returns the parser to
//   the leading blank phase, ready for a new text in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module integer_text_parser
   import itp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // Input register: one request waiting to be parsed.
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;

   // Response register.
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;

   logic    step;
   logic    load_out;
   logic    in_load;
   rsp_type core_result;

   // A request steps the core unless it ends a text and its response would
   // have nowhere to go.
   assign step      = in_valid_ff && (!in_item_ff.is_last || !out_valid_ff || !rsp_stall);
   assign load_out  = step && in_item_ff.is_last;
   assign req_stall = in_valid_ff && !step;
   assign in_load   = req_valid && !req_stall;

   assign in_valid_in  = in_load || (in_valid_ff && !step);
   assign out_valid_in = load_out || (out_valid_ff && rsp_stall);

   itp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (in_load) begin
         in_item_ff <= req_data;
      end
      if (load_out) begin
         out_data_ff <= core_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `ASSERT_CLK_RST(a_last_gives_rsp, load_out |=> rsp_valid, "no response for end of text")
   `ASSERT_CLK_RST(a_in_held, req_stall |=> in_valid_ff && $stable(in_item_ff), "request changed")
   `ASSERT_CLK(a_reset_idle, reset |=> !rsp_valid && !req_stall, "reset did not clear")

endmodule

`default_nettype wire
